// ===== sv/assert_macros.svh =====
// Assertion macros included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/brms_pkg.sv =====
// Shared types, constants and helper functions of the band-pass RMS ratio modulator.
package brms_pkg;

   localparam int COEF_W   = 31;
   localparam int RATIO_W  = 15;
   localparam int ENERGY_W = 17;
   localparam int SUM_W    = 64;
   localparam int ST_W     = 48;
   localparam int ACC_W    = 50;
   localparam int OPA_W    = 32;
   localparam int DEN_W    = 20;
   localparam int IDX_W    = 3;

   localparam logic [IDX_W-1:0] REG_B0     = 3'd0;
   localparam logic [IDX_W-1:0] REG_B1     = 3'd1;
   localparam logic [IDX_W-1:0] REG_B2     = 3'd2;
   localparam logic [IDX_W-1:0] REG_A1     = 3'd3;
   localparam logic [IDX_W-1:0] REG_A2     = 3'd4;
   localparam logic [IDX_W-1:0] REG_RATIO  = 3'd5;
   localparam logic [IDX_W-1:0] REG_STEREO = 3'd6;

   localparam logic signed [COEF_W-1:0] RST_B0 = 31'sd11192400;
   localparam logic signed [COEF_W-1:0] RST_B1 = 31'sd0;
   localparam logic signed [COEF_W-1:0] RST_B2 = -31'sd11192400;
   localparam logic signed [COEF_W-1:0] RST_A1 = -31'sd510089000;
   localparam logic signed [COEF_W-1:0] RST_A2 = 31'sd246050000;
   localparam logic [RATIO_W-1:0]       RST_RATIO = 15'd1024;

   localparam logic [RATIO_W-1:0]  UNITY_RATIO = 15'd256;
   localparam logic [ENERGY_W-1:0] FULL_ENERGY = 17'd65536;

   // Division by ten as a multiply by ceil(2^21/10) and a shift, exact below 2^18.
   localparam logic [17:0] DIV10_MUL = 18'd209716;
   localparam int          DIV10_SH  = 21;

   localparam logic signed [ACC_W-1:0] ST_MAX_X =
      {{(ACC_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ST_MIN_X =
      {{(ACC_W-ST_W+1){1'b1}}, {(ST_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] energy;
      logic [RATIO_W-1:0]  ratio;
   } merge_result_type;

   // Saturates a wide signed value to the filter state width.
   function automatic logic signed [ST_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
      logic signed [ST_W-1:0] r;
      if (v > ST_MAX_X) begin
         r = ST_MAX_X[ST_W-1:0];
      end else if (v < ST_MIN_X) begin
         r = ST_MIN_X[ST_W-1:0];
      end else begin
         r = v[ST_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/bandpass_rms_ratio_modulator.sv =====
// Top level of the band-pass RMS ratio modulator: registers, lanes, merge and output stage.
//
//   channel  direction  width                 contents
//   req      in         2*SAMPLE_BITS + last  stereo sample, tlast marks block end
//   rsp      out        32                    effective ratio and core energy
//   csr      in         31 + 3-bit index      coefficient, ratio and mode writes
//
// After a sample is accepted, req_tready stays low until both lanes have run the
// seven-step biquad sequence on each lane's single multiplier.
// A block end adds the T_MERGE state to hand the sums to the merge unit, which then
// runs a bit-serial divider per mean, a square root and the ratio steps while new
// samples are taken. A later block end waits for it.
// Reset is synchronous; it clears the filters, sums and count and loads the registers with their reset values.
// A stalled result holds in the output register without blocking the input.
module bandpass_rms_ratio_modulator #(
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_BLOCK   = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample_left, sample_right, zero padding
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // effective_ratio, core_energy
   output logic [31:0]                          rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic [brms_pkg::IDX_W-1:0]           csr_index,
   input  logic [brms_pkg::COEF_W-1:0]          csr_wdata
);
   import brms_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK);

   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_LANE  = 2'd1;
   localparam logic [1:0] T_MERGE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                last_ff, last_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   coef_set_type        coefs_ff;
   logic [RATIO_W-1:0]  ratio_reg_ff;
   logic                stereo_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   merge_result_type    rsp_data_ff;

   logic                accept;
   logic                busy_l, busy_r;
   logic [SUM_W-1:0]    sum_l, sum_r;
   logic                merge_start;
   logic                merge_idle, merge_done, merge_ack;
   merge_result_type    merge_res;

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;

   brms_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .clear      (merge_start),
      .coefs      (coefs_ff),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .busy       (busy_l),
      .square_sum (sum_l)
   );

   brms_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .clear      (merge_start),
      .coefs      (coefs_ff),
      .sample     (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .busy       (busy_r),
      .square_sum (sum_r)
   );

   brms_merge #(.SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .start      (merge_start),
      .sum_left   (sum_l),
      .sum_right  (sum_r),
      .count      (count_ff),
      .stereo     (stereo_ff),
      .base_ratio (ratio_reg_ff),
      .ack        (merge_ack),
      .idle       (merge_idle),
      .done       (merge_done),
      .result     (merge_res)
   );

   assign merge_start = (state_ff == T_MERGE) && merge_idle;
   assign merge_ack   = merge_done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      count_in = count_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               last_in  = req_tlast;
               count_in = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
               state_in = T_LANE;
            end
         end
         T_LANE: begin
            if (!busy_l && !busy_r) begin
               state_in = last_ff ? T_MERGE : T_IDLE;
            end
         end
         T_MERGE: begin
            if (merge_idle) begin
               count_in = '0;
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase

      if (merge_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         last_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         coefs_ff.b0  <= RST_B0;
         coefs_ff.b1  <= RST_B1;
         coefs_ff.b2  <= RST_B2;
         coefs_ff.a1  <= RST_A1;
         coefs_ff.a2  <= RST_A2;
         ratio_reg_ff <= RST_RATIO;
         stereo_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_B0:     coefs_ff.b0  <= csr_wdata;
               REG_B1:     coefs_ff.b1  <= csr_wdata;
               REG_B2:     coefs_ff.b2  <= csr_wdata;
               REG_A1:     coefs_ff.a1  <= csr_wdata;
               REG_A2:     coefs_ff.a2  <= csr_wdata;
               REG_RATIO:  ratio_reg_ff <= csr_wdata[RATIO_W-1:0];
               REG_STEREO: stereo_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (merge_ack) begin
         rsp_data_ff <= merge_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.energy, rsp_data_ff.ratio};

endmodule

// ===== sv/brms_lane.sv =====
// One channel lane: biquad band-pass on a shared multiplier and the square accumulator.
module brms_lane #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             clear,
   input  brms_pkg::coef_set_type           coefs,
   input  logic signed [SAMPLE_BITS-1:0]    sample,
   output logic                             busy,
   output logic [brms_pkg::SUM_W-1:0]       square_sum
);
   import brms_pkg::*;

   localparam int PS     = SAMPLE_BITS - 5;
   localparam int YS     = 33 - SAMPLE_BITS;
   localparam int PROD_W = OPA_W + SAMPLE_BITS;
   localparam logic signed [ST_W-1:0] Q_MAX =
      ST_W'((longint'(1) <<< (SAMPLE_BITS-1)) - longint'(1));
   localparam logic signed [ST_W-1:0] Q_MIN =
      ST_W'(-(longint'(1) <<< (SAMPLE_BITS-1)));

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_B0   = 3'd1;
   localparam logic [2:0] S_Y    = 3'd2;
   localparam logic [2:0] S_B1   = 3'd3;
   localparam logic [2:0] S_A1   = 3'd4;
   localparam logic [2:0] S_S0   = 3'd5;
   localparam logic [2:0] S_S1   = 3'd6;
   localparam logic [2:0] S_SQ   = 3'd7;

   logic [2:0]                    step_ff, step_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] yq_ff, yq_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [ST_W-1:0]        s0_ff, s0_in;
   logic signed [ST_W-1:0]        s1_ff, s1_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;

   logic signed [OPA_W-1:0]       op_a;
   logic signed [SAMPLE_BITS-1:0] op_b;
   logic signed [ACC_W-1:0]       scaled;
   logic signed [ST_W-1:0]        y_sat;
   logic signed [ST_W-1:0]        y_sh;
   logic [SUM_W:0]                sum_ext;

   always_comb begin
      case (step_ff)
         S_B0: begin
            op_a = OPA_W'(coefs.b0);
            op_b = x_ff;
         end
         S_Y: begin
            op_a = OPA_W'(coefs.b1);
            op_b = x_ff;
         end
         S_B1: begin
            op_a = OPA_W'(coefs.a1);
            op_b = yq_ff;
         end
         S_A1: begin
            op_a = OPA_W'(coefs.b2);
            op_b = x_ff;
         end
         S_S0: begin
            op_a = OPA_W'(coefs.a2);
            op_b = yq_ff;
         end
         default: begin
            op_a = OPA_W'(yq_ff);
            op_b = yq_ff;
         end
      endcase
      prod_in = op_a * op_b;

      scaled  = ACC_W'(prod_ff >>> PS);
      y_sat   = sat_state(scaled + ACC_W'(s0_ff));
      y_sh    = y_sat >>> YS;
      if (y_sh > Q_MAX) begin
         yq_in = Q_MAX[SAMPLE_BITS-1:0];
      end else if (y_sh < Q_MIN) begin
         yq_in = Q_MIN[SAMPLE_BITS-1:0];
      end else begin
         yq_in = y_sh[SAMPLE_BITS-1:0];
      end
      sum_ext = {1'b0, sum_ff} + (SUM_W+1)'(prod_ff[2*SAMPLE_BITS-1:0]);

      step_in = step_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      s0_in   = s0_ff;
      s1_in   = s1_ff;
      sum_in  = sum_ff;
      case (step_ff)
         S_IDLE: begin
            if (start) begin
               x_in    = sample;
               step_in = S_B0;
            end
            if (clear) begin
               sum_in = '0;
            end
         end
         S_B0: step_in = S_Y;
         S_Y:  step_in = S_B1;
         S_B1: begin
            acc_in  = scaled;
            step_in = S_A1;
         end
         S_A1: begin
            acc_in  = acc_ff - scaled;
            step_in = S_S0;
         end
         S_S0: begin
            s0_in   = sat_state(acc_ff + ACC_W'(s1_ff));
            acc_in  = scaled;
            step_in = S_S1;
         end
         S_S1: begin
            s1_in   = sat_state(acc_ff - scaled);
            step_in = S_SQ;
         end
         S_SQ: begin
            sum_in  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
            step_in = S_IDLE;
         end
         default: step_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
         s0_ff   <= '0;
         s1_ff   <= '0;
         sum_ff  <= '0;
      end else begin
         step_ff <= step_in;
         s0_ff   <= s0_in;
         s1_ff   <= s1_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (step_ff == S_Y) begin
         yq_ff <= yq_in;
      end
   end

   assign busy       = (step_ff != S_IDLE);
   assign square_sum = sum_ff;

endmodule

// ===== sv/brms_merge.sv =====
// Block-end merge: mean per channel (left only when stereo is off), larger mean, square root, energy and ratio.
module brms_merge #(
   parameter int SAMPLE_BITS = 24,
   parameter int CNT_W       = 17
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [brms_pkg::SUM_W-1:0]      sum_left,
   input  logic [brms_pkg::SUM_W-1:0]      sum_right,
   input  logic [CNT_W-1:0]                count,
   input  logic                            stereo,
   input  logic [brms_pkg::RATIO_W-1:0]    base_ratio,
   input  logic                            ack,
   output logic                            idle,
   output logic                            done,
   output brms_pkg::merge_result_type      result
);
   import brms_pkg::*;

   localparam int FRAC = SAMPLE_BITS - 1;
   localparam int THR  = 2 * FRAC - 4;
   localparam int IT_W = $clog2(SUM_W);
   localparam logic [IT_W-1:0] DIV_LAST = IT_W'(SUM_W - 1);
   localparam logic [SUM_W-1:0] BIT_TOP = SUM_W'(1) << (SUM_W - 2);

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_DIVL = 3'd1;
   localparam logic [2:0] M_DIVR = 3'd2;
   localparam logic [2:0] M_SQRT = 3'd3;
   localparam logic [2:0] M_MUL  = 3'd4;
   localparam logic [2:0] M_DIVQ = 3'd5;
   localparam logic [2:0] M_DONE = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [IT_W-1:0]       iter_ff, iter_in;
   logic [SUM_W-1:0]      num_ff, num_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [SUM_W-1:0]      sumr_ff, sumr_in;
   logic [SUM_W-1:0]      mean_ff, mean_in;
   logic [SUM_W-1:0]      v_ff, v_in;
   logic [SUM_W-1:0]      res_ff, res_in;
   logic [SUM_W-1:0]      bit_ff, bit_in;
   logic [ENERGY_W-1:0]   energy_ff, energy_in;
   logic [RATIO_W-1:0]    ratio_ff, ratio_in;

   logic [DEN_W:0]        rem_sh;
   logic                  ge;
   logic [SUM_W-1:0]      q_next;
   logic [SUM_W-1:0]      m_max;
   logic [SUM_W-1:0]      trial;
   logic [SUM_W-1:0]      res_next;
   logic [SUM_W+17:0]     e_wide;
   logic [RATIO_W-1:0]    r_excess;
   logic [31:0]           mprod;
   logic [33:0]           mprod3;
   logic [34:0]           q10_prod;

   always_comb begin
      rem_sh   = {rem_ff, num_ff[SUM_W-1]};
      ge       = (rem_sh >= {1'b0, den_ff});
      q_next   = {num_ff[SUM_W-2:0], ge};
      m_max    = (q_next > mean_ff) ? q_next : mean_ff;
      trial    = res_ff + bit_ff;
      res_next = (v_ff >= trial) ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
      e_wide   = {res_next, 18'b0} >> FRAC;
      r_excess = base_ratio - UNITY_RATIO;
      mprod    = r_excess * energy_ff;
      mprod3   = 34'(mprod) + {mprod, 1'b0};
      q10_prod = 35'(num_ff[16:0]) * 35'(DIV10_MUL);

      state_in  = state_ff;
      iter_in   = iter_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      sumr_in   = sumr_ff;
      mean_in   = mean_ff;
      v_in      = v_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      energy_in = energy_ff;
      ratio_in  = ratio_ff;

      if (state_ff == M_DIVL || state_ff == M_DIVR) begin
         rem_in  = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         num_in  = q_next;
         iter_in = iter_ff + 1'b1;
      end

      case (state_ff)
         M_IDLE: begin
            if (start) begin
               num_in   = sum_left;
               sumr_in  = sum_right;
               den_in   = DEN_W'(count);
               rem_in   = '0;
               iter_in  = '0;
               state_in = M_DIVL;
            end
         end
         M_DIVL: begin
            if (iter_ff == DIV_LAST) begin
               mean_in = q_next;
               v_in    = q_next;
               res_in  = '0;
               bit_in  = BIT_TOP;
               if (stereo) begin
                  num_in   = sumr_ff;
                  rem_in   = '0;
                  iter_in  = '0;
                  state_in = M_DIVR;
               end else begin
                  state_in = M_SQRT;
               end
            end
         end
         M_DIVR: begin
            if (iter_ff == DIV_LAST) begin
               mean_in  = m_max;
               v_in     = m_max;
               state_in = M_SQRT;
            end
         end
         M_SQRT: begin
            if (v_ff >= trial) begin
               v_in = v_ff - trial;
            end
            res_in = res_next;
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               energy_in = (|mean_ff[SUM_W-1:THR]) ? FULL_ENERGY : e_wide[ENERGY_W-1:0];
               state_in  = M_MUL;
            end
         end
         M_MUL: begin
            if (base_ratio <= UNITY_RATIO) begin
               ratio_in = UNITY_RATIO;
               state_in = M_DONE;
            end else begin
               num_in   = SUM_W'(mprod3 >> 16);
               state_in = M_DIVQ;
            end
         end
         M_DIVQ: begin
            ratio_in = base_ratio - RATIO_W'(q10_prod >> DIV10_SH);
            state_in = M_DONE;
         end
         M_DONE: begin
            if (ack) begin
               state_in = M_IDLE;
            end
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff   <= iter_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      sumr_ff   <= sumr_in;
      mean_ff   <= mean_in;
      v_ff      <= v_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      energy_ff <= energy_in;
      ratio_ff  <= ratio_in;
   end

   assign idle          = (state_ff == M_IDLE);
   assign done          = (state_ff == M_DONE);
   assign result.energy = energy_ff;
   assign result.ratio  = ratio_ff;

endmodule

// ===== sv/brms_checker.sv =====
// Port-level assertion checker for the band-pass RMS ratio modulator and its bind.
`include "assert_macros.svh"

module brms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `ASSERT_SAME(a_ratio_floor, clock, reset, rsp_tvalid, rsp_tdata[14:0] >= 15'd256)
   `ASSERT_SAME(a_energy_cap, clock, reset, rsp_tvalid, rsp_tdata[31:15] <= 17'd65536)
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind bandpass_rms_ratio_modulator brms_checker u_brms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
